// File: src/pso_pkg.sv
// pso_pkg: shared types, constants and helpers of the particle swarm update engine
// no dependencies; used by the interfaces, the lanes and the top level
package pso_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic [31:0]        cost_t;
  typedef logic [17:0]        gain_t;
  typedef logic [15:0]        rand_t;

  localparam int INDEX_W  = 11;
  localparam int REG_IDX_W = 2;
  localparam int COORDS   = 6;
  localparam int DIMS     = 3;
  localparam int NUM_DIST = 5;

  // input item modes
  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_INERTIA  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PERSONAL = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SOCIAL   = 2'd2;

  localparam gain_t INERTIA_RST  = 18'd47776;
  localparam gain_t PERSONAL_RST = 18'd97911;
  localparam gain_t SOCIAL_RST   = 18'd97911;

  // terminal points in integer units, scaled by the fraction width at the top
  localparam int FIXED_PTS [4][3] = '{'{1, 5, 1}, '{3, 2, 0}, '{5, 6, 1}, '{6, 3, 3}};

  // clamp a wide signed value to the signed 32-bit range
  function automatic word_t sat_word(input logic signed [39:0] v);
    word_t r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// File: src/pso_if.sv
// pso_if: valid/ready channel interfaces for input items, results and configuration
// depends on pso_pkg
interface pso_in_if import pso_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [INDEX_W-1:0]   particle_index;
  word_t                first_x;
  word_t                first_y;
  word_t                first_z;
  word_t                second_x;
  word_t                second_y;
  word_t                second_z;
  rand_t                rand_personal;
  rand_t                rand_social;

  modport source (output valid, mode, particle_index, first_x, first_y, first_z,
                  second_x, second_y, second_z, rand_personal, rand_social,
                  input ready);
  modport sink (input valid, mode, particle_index, first_x, first_y, first_z,
                second_x, second_y, second_z, rand_personal, rand_social,
                output ready);
endinterface

interface pso_out_if import pso_pkg::*; ();
  logic  valid;
  logic  ready;
  cost_t step_cost;
  logic  personal_improved;
  logic  global_improved;
  cost_t best_cost;
  word_t best_first_x;
  word_t best_first_y;
  word_t best_first_z;
  word_t best_second_x;
  word_t best_second_y;
  word_t best_second_z;

  modport source (output valid, step_cost, personal_improved, global_improved, best_cost,
                  best_first_x, best_first_y, best_first_z,
                  best_second_x, best_second_y, best_second_z,
                  input ready);
  modport sink (input valid, step_cost, personal_improved, global_improved, best_cost,
                best_first_x, best_first_y, best_first_z,
                best_second_x, best_second_y, best_second_z,
                output ready);
endinterface

interface pso_cfg_if import pso_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] reg_index;
  gain_t                data;

  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

// File: src/pso_ram.sv
// pso_ram: generic single-write, single-read memory with registered read data
// no dependencies
module pso_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/pso_dist_lane.sv
// pso_dist_lane: one distance lane, squared differences then a bit-pair square root
// depends on pso_pkg
module pso_dist_lane import pso_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t pt_a [DIMS],
  input  word_t pt_b [DIMS],
  output logic  done,
  output cost_t dist_len
);

  logic               busy;
  logic               rooting;
  logic [1:0]         k;
  logic signed [32:0] diff [DIMS];
  logic [63:0]        sq_q;
  logic [63:0]        sum;
  logic [63:0]        n;
  logic [63:0]        root;
  logic [63:0]        bitm;

  logic signed [32:0] d_sel;
  logic [32:0]        mag;
  logic [65:0]        sq_full;
  logic [64:0]        sum_wide;
  logic [63:0]        sum_next;
  logic [63:0]        trial;

  // squared magnitude of the selected difference
  always_comb begin
    d_sel    = (k == 2'd3) ? diff[0] : diff[k];
    mag      = d_sel[32] ? 33'(-d_sel) : 33'(d_sel);
    sq_full  = 66'(mag) * 66'(mag);
    sum_wide = {1'b0, sum} + {1'b0, sq_q};
    sum_next = sum_wide[64] ? '1 : sum_wide[63:0];
    trial    = root + bitm;
  end

  // accumulate three squares, then one root bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      rooting <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        for (int i = 0; i < DIMS; i++) begin
          diff[i] <= 33'(pt_a[i]) - 33'(pt_b[i]);
        end
        busy <= 1'b1;
        k    <= 2'd0;
        sum  <= '0;
      end else if (busy && !rooting) begin
        if (k != 2'd3) begin
          sq_q <= sq_full[63:0];
        end
        if (k != 2'd0) begin
          sum <= sum_next;
        end
        if (k == 2'd3) begin
          rooting <= 1'b1;
          n       <= sum_next;
          root    <= '0;
          bitm    <= 64'h4000_0000_0000_0000;
        end
        k <= k + 2'd1;
      end else if (rooting) begin
        if (n >= trial) begin
          n    <= n - trial;
          root <= (root >> 1) + bitm;
        end else begin
          root <= root >> 1;
        end
        bitm <= bitm >> 2;
        if (bitm[0]) begin
          rooting <= 1'b0;
          busy    <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign dist_len = root[31:0];

endmodule

// File: src/pso_cost_merge.sv
// pso_cost_merge: adds the five lane distances into one saturated cost
// depends on pso_pkg
module pso_cost_merge import pso_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  lanes_done,
  input  cost_t dist_len [NUM_DIST],
  output logic  valid,
  output cost_t cost
);

  logic [34:0] total;

  // wide sum of all lanes
  always_comb begin
    total = '0;
    for (int i = 0; i < NUM_DIST; i++) begin
      total = total + 35'(dist_len[i]);
    end
  end

  // registered saturated result
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= lanes_done;
    end
    if (lanes_done) begin
      cost <= (total[34:32] != 3'd0) ? '1 : total[31:0];
    end
  end

endmodule

// File: src/pso_coord_lane.sv
// pso_coord_lane: one coordinate lane, velocity and position update in three stages
// depends on pso_pkg
module pso_coord_lane import pso_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t x,
  input  word_t v,
  input  word_t pbest,
  input  word_t gbest,
  input  gain_t w,
  input  gain_t g1,
  input  gain_t g2,
  output logic  done,
  output word_t new_v,
  output word_t new_x
);

  logic               s1_valid;
  logic               s2_valid;
  logic signed [50:0] p_w;
  logic signed [51:0] p_1;
  logic signed [51:0] p_2;
  word_t              x1;
  word_t              x2;

  logic signed [32:0] dp;
  logic signed [32:0] dg;
  logic signed [39:0] t;
  logic signed [39:0] xs;

  always_comb begin
    dp = 33'(pbest) - 33'(x);
    dg = 33'(gbest) - 33'(x);
    t  = 40'(p_w >>> 16) + 40'(p_1 >>> 16) + 40'(p_2 >>> 16);
    xs = 40'(x2) + 40'(new_v);
  end

  // stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= start;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
  end

  // products, velocity, position
  always_ff @(posedge clk) begin
    if (start) begin
      p_w <= 51'($signed({1'b0, w})) * 51'(v);
      p_1 <= 52'($signed({1'b0, g1})) * 52'(dp);
      p_2 <= 52'($signed({1'b0, g2})) * 52'(dg);
      x1  <= x;
    end
    if (s1_valid) begin
      new_v <= sat_word(t);
      x2    <= x1;
    end
    if (s2_valid) begin
      new_x <= sat_word(xs);
    end
  end

endmodule

// File: src/pso_particle_update_engine.sv
// pso_particle_update_engine: particle table, five distance lanes with a cost merge,
// six coordinate lanes; depends on pso_pkg, pso_if, pso_ram and the lane modules
// sequence: a load or out-of-range item goes straight to the done state after acceptance;
// an update runs the 32-step square root in the distance lanes before the coordinate lanes
// throughput: one item at a time, next item accepted once the previous one is done
// reset: synchronous; gains and global best reset, particle memories are not cleared
module pso_particle_update_engine import pso_pkg::*; #(
  parameter int NUM_PARTICLES = 2048,
  parameter int FRAC_BITS     = 16
) (
  input  logic          clk,
  input  logic          rst,
  pso_in_if.sink        in_ch,
  pso_out_if.source     out_ch,
  pso_cfg_if.sink       cfg
);

  localparam int AW = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;
  localparam int VINIT_I = ((1 << FRAC_BITS) + 50) / 100;
  localparam word_t VINIT = 32'(VINIT_I);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_START = 4'd2;
  localparam logic [3:0] ST_COST  = 4'd3;
  localparam logic [3:0] ST_BEST  = 4'd4;
  localparam logic [3:0] ST_UPD   = 4'd5;
  localparam logic [3:0] ST_WAITU = 4'd6;
  localparam logic [3:0] ST_WRITE = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]    state;
  gain_t         inertia;
  gain_t         pgain;
  gain_t         sgain;
  word_t         gb [COORDS];
  cost_t         gb_cost;
  logic [AW-1:0] idx_q;
  rand_t         r1_q;
  rand_t         r2_q;
  gain_t         g1_q;
  gain_t         g2_q;
  word_t         x_q [COORDS];
  word_t         v_q [COORDS];
  word_t         pb_q [COORDS];
  cost_t         pc_q;
  cost_t         cost_q;
  logic          pimp_q;
  logic          gimp_q;

  logic          out_valid;
  cost_t         o_cost;
  logic          o_pimp;
  logic          o_gimp;
  cost_t         o_best;
  word_t         o_pos [COORDS];

  logic          in_acc;
  logic          in_range;
  logic          load_we;
  logic          upd_we;
  logic [AW-1:0] waddr;
  word_t         load_pt [COORDS];
  word_t         pos_wd [COORDS];
  word_t         vel_wd [COORDS];
  word_t         pos_rd [COORDS];
  word_t         vel_rd [COORDS];
  word_t         pb_rd [COORDS];
  cost_t         pc_wd;
  cost_t         pc_rd;
  logic [33:0]   g1_full;
  logic [33:0]   g2_full;

  word_t         lane_a [NUM_DIST][DIMS];
  word_t         lane_b [NUM_DIST][DIMS];
  logic          dist_done [NUM_DIST];
  cost_t         dist_len [NUM_DIST];
  logic          all_dist_done;
  logic          merge_valid;
  cost_t         merge_cost;

  word_t         pb_eff [COORDS];
  logic          coord_done [COORDS];
  word_t         nv [COORDS];
  word_t         nx [COORDS];

  // handshakes
  assign in_ch.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_range    = 32'(in_ch.particle_index) < 32'(NUM_PARTICLES);

  // memory write selection: load on acceptance, update in the write state
  always_comb begin
    load_pt[0] = in_ch.first_x;
    load_pt[1] = in_ch.first_y;
    load_pt[2] = in_ch.first_z;
    load_pt[3] = in_ch.second_x;
    load_pt[4] = in_ch.second_y;
    load_pt[5] = in_ch.second_z;
    load_we = in_acc && (in_ch.mode == MODE_LOAD) && in_range;
    upd_we  = (state == ST_WRITE);
    waddr   = upd_we ? idx_q : AW'(in_ch.particle_index);
    for (int k = 0; k < COORDS; k++) begin
      pos_wd[k] = upd_we ? nx[k] : load_pt[k];
      vel_wd[k] = upd_we ? nv[k] : VINIT;
      pb_eff[k] = pimp_q ? x_q[k] : pb_q[k];
    end
    pc_wd   = upd_we ? cost_q : '1;
    g1_full = 34'(pgain) * 34'(r1_q);
    g2_full = 34'(sgain) * 34'(r2_q);
  end

  // particle memories: position, velocity and personal best, one of each per coordinate
  for (genvar k = 0; k < COORDS; k++) begin : g_coord_mem
    pso_ram #(.WIDTH(32), .DEPTH(NUM_PARTICLES)) u_pos (
      .clk(clk), .we(load_we || upd_we), .waddr(waddr), .wdata(pos_wd[k]),
      .raddr(idx_q), .rdata(pos_rd[k])
    );
    pso_ram #(.WIDTH(32), .DEPTH(NUM_PARTICLES)) u_vel (
      .clk(clk), .we(load_we || upd_we), .waddr(waddr), .wdata(vel_wd[k]),
      .raddr(idx_q), .rdata(vel_rd[k])
    );
    pso_ram #(.WIDTH(32), .DEPTH(NUM_PARTICLES)) u_pb (
      .clk(clk), .we(upd_we && pimp_q), .waddr(waddr), .wdata(x_q[k]),
      .raddr(idx_q), .rdata(pb_rd[k])
    );
  end

  pso_ram #(.WIDTH(32), .DEPTH(NUM_PARTICLES)) u_pcost (
    .clk(clk), .we(load_we || (upd_we && pimp_q)), .waddr(waddr), .wdata(pc_wd),
    .raddr(idx_q), .rdata(pc_rd)
  );

  // distance lane operands: terminals and the two steiner points
  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      lane_a[0][d] = 32'(FIXED_PTS[0][d] * (1 << FRAC_BITS));
      lane_b[0][d] = pos_rd[d];
      lane_a[1][d] = 32'(FIXED_PTS[1][d] * (1 << FRAC_BITS));
      lane_b[1][d] = pos_rd[d];
      lane_a[2][d] = pos_rd[d];
      lane_b[2][d] = pos_rd[DIMS + d];
      lane_a[3][d] = 32'(FIXED_PTS[2][d] * (1 << FRAC_BITS));
      lane_b[3][d] = pos_rd[DIMS + d];
      lane_a[4][d] = 32'(FIXED_PTS[3][d] * (1 << FRAC_BITS));
      lane_b[4][d] = pos_rd[DIMS + d];
    end
    all_dist_done = 1'b1;
    for (int i = 0; i < NUM_DIST; i++) begin
      all_dist_done = all_dist_done && dist_done[i];
    end
  end

  for (genvar i = 0; i < NUM_DIST; i++) begin : g_dist
    pso_dist_lane u_lane (
      .clk(clk), .rst(rst), .start(state == ST_START),
      .pt_a(lane_a[i]), .pt_b(lane_b[i]), .done(dist_done[i]), .dist_len(dist_len[i])
    );
  end

  pso_cost_merge u_merge (
    .clk(clk), .rst(rst), .lanes_done(all_dist_done), .dist_len(dist_len),
    .valid(merge_valid), .cost(merge_cost)
  );

  for (genvar k = 0; k < COORDS; k++) begin : g_upd
    pso_coord_lane u_lane (
      .clk(clk), .rst(rst), .start(state == ST_UPD),
      .x(x_q[k]), .v(v_q[k]), .pbest(pb_eff[k]), .gbest(gb[k]),
      .w(inertia), .g1(g1_q), .g2(g2_q),
      .done(coord_done[k]), .new_v(nv[k]), .new_x(nx[k])
    );
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inertia <= INERTIA_RST;
      pgain   <= PERSONAL_RST;
      sgain   <= SOCIAL_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        REG_INERTIA:  inertia <= cfg.data;
        REG_PERSONAL: pgain   <= cfg.data;
        REG_SOCIAL:   sgain   <= cfg.data;
        default: ;
      endcase
    end
  end

  // sequencer, best tracking and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      gb_cost   <= '1;
      for (int k = 0; k < COORDS; k++) begin
        gb[k] <= '0;
      end
    end else begin
      if (out_valid && out_ch.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            idx_q  <= AW'(in_ch.particle_index);
            r1_q   <= in_ch.rand_personal;
            r2_q   <= in_ch.rand_social;
            cost_q <= '0;
            pimp_q <= 1'b0;
            gimp_q <= 1'b0;
            state  <= (in_ch.mode == MODE_UPDATE && in_range) ? ST_RD : ST_DONE;
          end
        end
        ST_RD: begin
          state <= ST_START;
        end
        ST_START: begin
          x_q   <= pos_rd;
          v_q   <= vel_rd;
          pb_q  <= pb_rd;
          pc_q  <= pc_rd;
          g1_q  <= g1_full[33:16];
          g2_q  <= g2_full[33:16];
          state <= ST_COST;
        end
        ST_COST: begin
          if (merge_valid) begin
            cost_q <= merge_cost;
            state  <= ST_BEST;
          end
        end
        ST_BEST: begin
          pimp_q <= cost_q < pc_q;
          gimp_q <= cost_q < gb_cost;
          if (cost_q < gb_cost) begin
            gb_cost <= cost_q;
            gb      <= x_q;
          end
          state <= ST_UPD;
        end
        ST_UPD: begin
          state <= ST_WAITU;
        end
        ST_WAITU: begin
          if (coord_done[0]) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            o_cost    <= cost_q;
            o_pimp    <= pimp_q;
            o_gimp    <= gimp_q;
            o_best    <= gb_cost;
            o_pos     <= gb;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result channel
  assign out_ch.valid             = out_valid;
  assign out_ch.step_cost         = o_cost;
  assign out_ch.personal_improved = o_pimp;
  assign out_ch.global_improved   = o_gimp;
  assign out_ch.best_cost         = o_best;
  assign out_ch.best_first_x      = o_pos[0];
  assign out_ch.best_first_y      = o_pos[1];
  assign out_ch.best_first_z      = o_pos[2];
  assign out_ch.best_second_x     = o_pos[3];
  assign out_ch.best_second_y     = o_pos[4];
  assign out_ch.best_second_z     = o_pos[5];

endmodule

// File: dv/pso_particle_update_engine_tb.sv
// pso_particle_update_engine_tb: self-checking bench for the particle swarm update engine
// drives loads and updates with gain changes between phases, predicts every result
// depends on pso_pkg, pso_if and the engine top level
module pso_particle_update_engine_tb;
  import pso_pkg::*;

  typedef struct {
    logic                mode;
    logic [INDEX_W-1:0]  idx;
    logic [5:0][31:0]    pos;
    rand_t               r1;
    rand_t               r2;
  } swarm_item_t;

  // step_cost, personal flag, global flag, best cost, six best coordinates
  typedef logic [9:0][31:0] outcome_t;

  localparam int NPART = 2048;
  localparam int TAIL_CYCLES = 64;
  localparam int Q = 65536;

  logic clk;
  logic rst;
  int   cyc;
  int   errors;
  int   results_seen;

  pso_in_if  in_ch ();
  pso_out_if out_ch ();
  pso_cfg_if cfg_ch ();

  pso_particle_update_engine DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // predictor state
  gain_t inertia_w, pers_gain, soc_gain;
  word_t pos_tab [NPART][6];
  word_t vel_tab [NPART][6];
  word_t pbest_tab [NPART][6];
  cost_t pcost_tab [NPART];
  word_t gbest_pos [6];
  cost_t gbest_cost;

  swarm_item_t pending_items[$];
  outcome_t    expected_outcomes[$];
  bit          loaded_at_gen [NPART];
  bit          pb_ready_gen [NPART];
  bit          in_fired;
  bit          held_once;
  int          hold_left;
  logic        calm;

  assign calm = (cyc >= 30000) && (cyc < 45000);

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // floor integer square root of a 64-bit value
  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned rt, b;
    rt = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= rt + b) begin
        n = n - (rt + b);
        rt = (rt >> 1) + b;
      end else begin
        rt = rt >> 1;
      end
      b = b >> 2;
    end
    return rt;
  endfunction

  // euclidean distance with a saturating squared sum
  function automatic longint unsigned span(longint ax, longint ay, longint az,
                                           longint bx, longint by, longint bz);
    longint          d [3];
    longint unsigned m, sq, sum;
    sum = 0;
    d[0] = ax - bx;
    d[1] = ay - by;
    d[2] = az - bz;
    for (int k = 0; k < 3; k++) begin
      m = (d[k] < 0) ? -d[k] : d[k];
      sq = m * m;
      if (sum > (64'hffff_ffff_ffff_ffff - sq)) sum = 64'hffff_ffff_ffff_ffff;
      else sum = sum + sq;
    end
    return root64(sum);
  endfunction

  function automatic longint fp(int i, int k);
    return longint'(FIXED_PTS[i][k]) * Q;
  endfunction

  // steiner tree length of one particle position
  function automatic cost_t tree_length(word_t p [6]);
    longint          s [6];
    longint unsigned total;
    for (int k = 0; k < 6; k++) s[k] = longint'(p[k]);
    total = span(fp(0, 0), fp(0, 1), fp(0, 2), s[0], s[1], s[2])
          + span(fp(1, 0), fp(1, 1), fp(1, 2), s[0], s[1], s[2])
          + span(s[0], s[1], s[2], s[3], s[4], s[5])
          + span(fp(2, 0), fp(2, 1), fp(2, 2), s[3], s[4], s[5])
          + span(fp(3, 0), fp(3, 1), fp(3, 2), s[3], s[4], s[5]);
    return (total > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : total[31:0];
  endfunction

  function automatic word_t clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // apply one accepted item to the predictor and queue its outcome
  task automatic advance_swarm(swarm_item_t it);
    outcome_t o;
    word_t    xs [6];
    longint   g1, g2, t, xv;
    word_t    nv;
    o = '0;
    if (it.mode == MODE_LOAD) begin
      for (int k = 0; k < 6; k++) begin
        pos_tab[it.idx][k] = it.pos[k];
        vel_tab[it.idx][k] = 32'sd655;
      end
      pcost_tab[it.idx] = 32'hffff_ffff;
    end else begin
      g1 = longint'((64'(pers_gain) * 64'(it.r1)) >> 16);
      g2 = longint'((64'(soc_gain) * 64'(it.r2)) >> 16);
      xs = pos_tab[it.idx];
      o[0] = tree_length(xs);
      if (o[0] < pcost_tab[it.idx]) begin
        pbest_tab[it.idx] = xs;
        pcost_tab[it.idx] = o[0];
        o[1] = 1;
      end
      if (o[0] < gbest_cost) begin
        gbest_pos = xs;
        gbest_cost = o[0];
        o[2] = 1;
      end
      for (int k = 0; k < 6; k++) begin
        xv = longint'(xs[k]);
        t = ((longint'(inertia_w) * longint'(vel_tab[it.idx][k])) >>> 16)
          + ((g1 * (longint'(pbest_tab[it.idx][k]) - xv)) >>> 16)
          + ((g2 * (longint'(gbest_pos[k]) - xv)) >>> 16);
        nv = clamp32(t);
        vel_tab[it.idx][k] = nv;
        pos_tab[it.idx][k] = clamp32(xv + longint'(nv));
      end
    end
    o[3] = gbest_cost;
    for (int k = 0; k < 6; k++) o[4 + k] = gbest_pos[k];
    expected_outcomes.push_back(o);
  endtask

  // input driver: changes at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fired) begin
      if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
        in_ch.valid          <= 1'b1;
        in_ch.mode           <= pending_items[0].mode;
        in_ch.particle_index <= pending_items[0].idx;
        in_ch.first_x        <= pending_items[0].pos[0];
        in_ch.first_y        <= pending_items[0].pos[1];
        in_ch.first_z        <= pending_items[0].pos[2];
        in_ch.second_x       <= pending_items[0].pos[3];
        in_ch.second_y       <= pending_items[0].pos[4];
        in_ch.second_z       <= pending_items[0].pos[5];
        in_ch.rand_personal  <= pending_items[0].r1;
        in_ch.rand_social    <= pending_items[0].r2;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    in_fired = 1'b0;
  end

  // input transaction accepted: predict it
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      in_fired = 1'b1;
      advance_swarm(pending_items.pop_front());
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!held_once && results_seen >= 150) begin
      held_once = 1'b1;
      hold_left = 400;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 28);
    end
  end

  // result monitor
  always @(posedge clk) begin
    outcome_t got, want;
    string    fname [10];
    fname = '{"step_cost", "personal_improved", "global_improved", "best_cost",
              "best_first_x", "best_first_y", "best_first_z",
              "best_second_x", "best_second_y", "best_second_z"};
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.best_second_z, out_ch.best_second_y, out_ch.best_second_x,
             out_ch.best_first_z, out_ch.best_first_y, out_ch.best_first_x,
             out_ch.best_cost, 31'd0, out_ch.global_improved,
             31'd0, out_ch.personal_improved, out_ch.step_cost};
      results_seen <= results_seen + 1;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result transaction, step_cost %h", $time, got[0]);
        errors++;
      end else begin
        want = expected_outcomes.pop_front();
        for (int f = 0; f < 10; f++) begin
          if (got[f] !== want[f]) begin
            $display("%0t: %s expected %h actual %h", $time, fname[f], want[f], got[f]);
            errors++;
          end
        end
      end
    end
  end

  // gain register write through the configuration channel
  task automatic write_gain(logic [REG_IDX_W-1:0] ix, gain_t val);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= ix;
    cfg_ch.data      <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (ix)
      REG_INERTIA:  inertia_w = val;
      REG_PERSONAL: pers_gain = val;
      REG_SOCIAL:   soc_gain  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || expected_outcomes.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic push_load(int ix, logic [5:0][31:0] p);
    swarm_item_t it;
    it.mode = MODE_LOAD;
    it.idx  = INDEX_W'(ix);
    it.pos  = p;
    it.r1   = rand_t'($urandom);
    it.r2   = rand_t'($urandom);
    loaded_at_gen[ix] = 1'b1;
    pending_items.push_back(it);
  endtask

  // the first update after a bounded load always gives a finite cost,
  // so the personal best of that particle is written from here on
  task automatic push_update(int ix, rand_t a, rand_t b);
    swarm_item_t it;
    it.mode = MODE_UPDATE;
    it.idx  = INDEX_W'(ix);
    it.pos  = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it.r1   = a;
    it.r2   = b;
    pb_ready_gen[ix] = 1'b1;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(8 * Q) - Q;
    endcase
  endfunction

  function automatic rand_t pick_rand();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return rand_t'($urandom);
    endcase
  endfunction

  // random traffic: mostly updates over a small hot set of particles
  task automatic random_traffic(int n);
    int ix;
    logic [5:0][31:0] p;
    for (int i = 0; i < n; i++) begin
      ix = ($urandom_range(9) < 7) ? $urandom_range(31) : $urandom_range(NPART - 1);
      if (!loaded_at_gen[ix] || $urandom_range(99) < 25) begin
        // bounded coordinates until the personal best has been written once
        for (int k = 0; k < 6; k++) begin
          p[k] = pb_ready_gen[ix] ? pick_coord() : $urandom_range(8 * Q) - Q;
        end
        push_load(ix, p);
      end else begin
        push_update(ix, pick_rand(), pick_rand());
      end
    end
  endtask

  // stimulus
  initial begin
    logic [5:0][31:0] p;
    gain_t            settings [5][3];
    errors       = 0;
    results_seen = 0;
    hold_left    = 0;
    held_once    = 1'b0;
    in_fired     = 1'b0;
    cyc          = 0;
    inertia_w    = INERTIA_RST;
    pers_gain    = PERSONAL_RST;
    soc_gain     = SOCIAL_RST;
    gbest_cost   = 32'hffff_ffff;
    for (int k = 0; k < 6; k++) gbest_pos[k] = '0;
    for (int i = 0; i < NPART; i++) begin
      loaded_at_gen[i] = 1'b0;
      pb_ready_gen[i]  = 1'b0;
    end
    rst                  = 1'b1;
    in_ch.valid          = 1'b0;
    in_ch.mode           = MODE_LOAD;
    in_ch.particle_index = '0;
    in_ch.first_x        = '0;
    in_ch.first_y        = '0;
    in_ch.first_z        = '0;
    in_ch.second_x       = '0;
    in_ch.second_y       = '0;
    in_ch.second_z       = '0;
    in_ch.rand_personal  = '0;
    in_ch.rand_social    = '0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.reg_index     = REG_INERTIA;
    cfg_ch.data          = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // seed personal bests with a finite cost before the extreme positions
    push_load(1, '0);
    push_update(1, 16'h4000, 16'h4000);
    push_load(2, '0);
    push_update(2, 16'h4000, 16'h4000);
    push_load(2047, '0);
    push_update(2047, 16'h4000, 16'h4000);

    // directed: extremes, exact terminal points, ties
    push_load(0, {32'(2 * Q), 32'(4 * Q), 32'(5 * Q), 32'(1 * Q), 32'(4 * Q), 32'(3 * Q)});
    push_load(1, {6{32'h7fffffff}});
    push_load(2, {6{32'h80000000}});
    push_load(3, '0);
    push_load(2047, {32'h80000000, 32'h7fffffff, 32'h80000000,
                     32'h7fffffff, 32'h80000000, 32'h7fffffff});
    push_load(4, {32'(1 * Q), 32'(6 * Q), 32'(5 * Q), 32'(1 * Q), 32'(5 * Q), 32'(1 * Q)});
    push_update(1, 16'hffff, 16'hffff);
    push_update(2, 16'h0000, 16'h0000);
    push_update(3, 16'hffff, 16'h0000);
    push_update(0, 16'h0000, 16'hffff);
    push_update(2047, 16'h8000, 16'h8000);
    push_update(4, 16'hffff, 16'hffff);
    push_update(0, 16'hffff, 16'hffff);
    push_update(0, 16'h1234, 16'hfedc);
    // reload the same position: equal cost must not replace the global best
    push_load(4, {32'(1 * Q), 32'(6 * Q), 32'(5 * Q), 32'(1 * Q), 32'(5 * Q), 32'(1 * Q)});
    push_update(4, 16'h0001, 16'h0001);
    push_update(1, 16'h7fff, 16'h7fff);
    drain();

    // gain settings per phase: reset values, zeros, maxima, two random
    settings[0] = '{INERTIA_RST, PERSONAL_RST, SOCIAL_RST};
    settings[1] = '{18'd0, 18'd0, 18'd0};
    settings[2] = '{18'h3ffff, 18'h3ffff, 18'h3ffff};
    settings[3] = '{gain_t'($urandom), gain_t'($urandom), gain_t'($urandom)};
    settings[4] = '{gain_t'($urandom_range(65536)), gain_t'($urandom_range(131072)),
                    gain_t'($urandom_range(131072))};
    for (int ph = 0; ph < 5; ph++) begin
      write_gain(REG_INERTIA, settings[ph][0]);
      write_gain(REG_PERSONAL, settings[ph][1]);
      write_gain(REG_SOCIAL, settings[ph][2]);
      random_traffic(287);
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #(8 * 3000000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
